/* rtl/core/pidc_pkg.sv */
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared types, widths and helpers of the clamped PID controller.
// ----------------------------------------------------------------------------
package pidc_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int DATA_W  = 32;   // error, gains, integral, output
    localparam int LIM_W   = 31;
    localparam int DT_W    = 16;
    localparam int DT_FRAC = 16;
    localparam int MUL_A_W = 32;   // multiplier operand, stepped one bit a cycle
    localparam int MUL_B_W = 49;   // multiplicand magnitude
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int DIVD_W  = 49;   // |diff| << DT_FRAC
    localparam int SUM_W   = 64;
    localparam int TERM_CAP_BIT = 60;
    localparam int IDX_W   = 3;

    localparam logic [IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
    localparam logic [IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
    localparam logic [IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
    localparam logic [IDX_W-1:0] REG_INTEG_LIM  = 3'd3;
    localparam logic [IDX_W-1:0] REG_OUT_LIM    = 3'd4;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_MUL_ET = 7'b0000010,
        ST_DIV    = 7'b0000100,
        ST_MUL_P  = 7'b0001000,
        ST_MUL_I  = 7'b0010000,
        ST_MUL_D  = 7'b0100000,
        ST_FIN    = 7'b1000000
    } state_t;

    // symmetric clamp of a wide signed value to +/-lim
    function automatic logic signed [DATA_W-1:0] clamp_sym(
        input logic signed [SUM_W-1:0] v,
        input logic [LIM_W-1:0]        lim
    );
        logic signed [SUM_W-1:0] lim_w;
        lim_w = $signed({{(SUM_W-LIM_W){1'b0}}, lim});
        if (v > lim_w)
            return $signed({1'b0, lim});
        else if (v < -lim_w)
            return -$signed({1'b0, lim});
        else
            return v[DATA_W-1:0];
    endfunction

endpackage

/* rtl/core/pidc_mul.sv */
// ----------------------------------------------------------------------------
// pidc_mul
// Bit-serial unsigned shift-add multiplier, one operand bit per cycle.
// ----------------------------------------------------------------------------
module pidc_mul import pidc_pkg::*; #(
    parameter int A_W = MUL_A_W,
    parameter int B_W = MUL_B_W
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [A_W-1:0]       a,
    input  logic [B_W-1:0]       b,
    output logic                 done,
    output logic [A_W+B_W-1:0]   prod
);
    localparam int CNT_W = $clog2(A_W + 1);

    logic [B_W-1:0]   hi_reg;
    logic [A_W-1:0]   lo_reg;
    logic [B_W-1:0]   b_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [B_W:0]     sum_next;

    assign sum_next = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, b_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(A_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            hi_reg <= '0;
            lo_reg <= a;
            b_reg  <= b;
        end
        else if (busy_reg)
        begin
            hi_reg <= sum_next[B_W:1];
            lo_reg <= {sum_next[0], lo_reg[A_W-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = {hi_reg, lo_reg};

endmodule

/* rtl/core/pidc_div.sv */
// ----------------------------------------------------------------------------
// pidc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pidc_div import pidc_pkg::*; #(
    parameter int N_W = DIVD_W,
    parameter int D_W = DT_W
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic           done,
    output logic [N_W-1:0] quotient
);
    localparam int CNT_W = $clog2(N_W + 1);

    logic [N_W-1:0]   q_reg;
    logic [D_W-1:0]   rem_reg;
    logic [D_W-1:0]   dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [D_W:0]     rem_sh;
    logic             ge;
    logic [D_W:0]     rem_sub;

    assign rem_sh  = {rem_reg, q_reg[N_W-1]};
    assign ge      = rem_sh >= {1'b0, dvs_reg};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(N_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so the top bit drops safely
            rem_reg <= ge ? rem_sub[D_W-1:0] : rem_sh[D_W-1:0];
            q_reg   <= {q_reg[N_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

/* rtl/core/pid_controller_clamped.sv */
// Sequence: a clear or a zero time step goes straight to the finish state;
// an update makes four passes of the bit-serial multiplier plus one of the
// divider for the derivative, each started by a registered start pulse.
// Flow: one item at a time; the next transfer is taken the cycle after the
// result is handed to the output register.
// Reset: asynchronous active low; gains, limits, integral and last error clear to zero.
// ----------------------------------------------------------------------------
// pid_controller_clamped
// Fixed-point PID controller with integral clamp and output clamp.
// ----------------------------------------------------------------------------
module pid_controller_clamped import pidc_pkg::*; #(
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // input channel
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     opcode,
    input  logic signed [DATA_W-1:0] error_sample,
    input  logic [DT_W-1:0]          time_step,
    // output channel
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] control_out,
    output logic                     step_rejected,
    // configuration
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [IDX_W-1:0]         cfg_index,
    input  logic [DATA_W-1:0]        cfg_data
);
    localparam logic [DIVD_W-1:0] DLIM = DIVD_W'(1) << (VALUE_WIDTH_DEF - 1);
    localparam logic [PROD_W-1:0] TERM_CAP = PROD_W'(1) << TERM_CAP_BIT;

    state_t                    state_reg;
    logic signed [DATA_W-1:0]  prop_gain_reg, integ_gain_reg, deriv_gain_reg;
    logic [LIM_W-1:0]          integ_lim_reg, out_lim_reg;
    logic signed [DATA_W-1:0]  integ_reg, last_reg;
    logic signed [DATA_W-1:0]  err_reg;
    logic [DT_W-1:0]           dt_reg;
    logic [MUL_B_W-1:0]        deriv_mag_reg;
    logic                      deriv_neg_reg;
    logic                      diff_neg_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [DATA_W-1:0]  res_val_reg;
    logic                      res_rej_reg;
    logic                      out_valid_reg;
    logic signed [DATA_W-1:0]  out_val_reg;
    logic                      out_rej_reg;

    logic                      mul_start_reg;
    logic [MUL_A_W-1:0]        mul_a_reg;
    logic [MUL_B_W-1:0]        mul_b_reg;
    logic                      term_neg_reg;
    logic                      mul_done;
    logic [PROD_W-1:0]         mul_prod;

    logic                      div_start_reg;
    logic [DIVD_W-1:0]         div_n_reg;
    logic                      div_done;
    logic [DIVD_W-1:0]         div_q;

    logic                      in_xfer;
    logic                      cfg_xfer;

    // combinational helpers
    logic signed [48:0]        et_signed;
    logic signed [32:0]        et_shift;
    logic signed [SUM_W-1:0]   integ_sum;
    logic signed [DATA_W-1:0]  integ_new;
    logic signed [32:0]        diff;
    logic [32:0]               diff_mag;
    logic [DIVD_W-1:0]         dq_sat;
    logic [PROD_W-1:0]         prod_sh;
    logic [TERM_CAP_BIT:0]     term_mag;
    logic signed [SUM_W-1:0]   term;
    logic signed [SUM_W-1:0]   sum_next;
    logic [MUL_A_W-1:0]        err_mag;
    logic [MUL_A_W-1:0]        ig_mag;
    logic [MUL_A_W-1:0]        dg_mag;
    logic [MUL_A_W-1:0]        integ_mag;
    logic signed [DATA_W-1:0]  clamp_in;

    pidc_mul #(
        .A_W (MUL_A_W),
        .B_W (MUL_B_W)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start_reg),
        .a     (mul_a_reg),
        .b     (mul_b_reg),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    pidc_div #(
        .N_W (DIVD_W),
        .D_W (DT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (div_n_reg),
        .divisor  (dt_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;

    assign err_mag   = err_reg[DATA_W-1] ? MUL_A_W'(-err_reg) : MUL_A_W'(err_reg);
    assign ig_mag    = integ_gain_reg[DATA_W-1] ? MUL_A_W'(-integ_gain_reg)
                                                : MUL_A_W'(integ_gain_reg);
    assign dg_mag    = deriv_gain_reg[DATA_W-1] ? MUL_A_W'(-deriv_gain_reg)
                                                : MUL_A_W'(deriv_gain_reg);
    assign integ_mag = integ_reg[DATA_W-1] ? MUL_A_W'(-integ_reg) : MUL_A_W'(integ_reg);

    // e * dt with floor shift
    always_comb
    begin
        et_signed = $signed({1'b0, mul_prod[47:0]});
        if (err_reg[DATA_W-1])
            et_signed = -et_signed;
        et_shift  = et_signed[48:DT_FRAC];
        integ_sum = SUM_W'(integ_reg) + SUM_W'(et_shift);
        integ_new = clamp_sym(integ_sum, integ_lim_reg);
    end

    assign diff     = 33'(err_reg) - 33'(last_reg);
    assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);

    always_comb
    begin
        if (diff_neg_reg)
            dq_sat = (div_q > DLIM) ? DLIM : div_q;
        else
            dq_sat = (div_q > DLIM - 1'b1) ? DLIM - 1'b1 : div_q;
    end

    // gain term: >> FRAC_BITS toward zero, magnitude capped
    always_comb
    begin
        prod_sh  = mul_prod >> FRAC_BITS;
        term_mag = (prod_sh > TERM_CAP) ? TERM_CAP[TERM_CAP_BIT:0]
                                        : prod_sh[TERM_CAP_BIT:0];
        term     = $signed({{(SUM_W-TERM_CAP_BIT-1){1'b0}}, term_mag});
        if (term_neg_reg)
            term = -term;
        sum_next = sum_reg + term;
        clamp_in = clamp_sym(sum_next, out_lim_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            prop_gain_reg  <= '0;
            integ_gain_reg <= '0;
            deriv_gain_reg <= '0;
            integ_lim_reg  <= '0;
            out_lim_reg    <= '0;
            integ_reg      <= '0;
            last_reg       <= '0;
            mul_start_reg  <= 1'b0;
            div_start_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;

            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            if (cfg_xfer)
            begin
                unique case (cfg_index)
                    REG_PROP_GAIN:  prop_gain_reg  <= cfg_data;
                    REG_INTEG_GAIN: integ_gain_reg <= cfg_data;
                    REG_DERIV_GAIN: deriv_gain_reg <= cfg_data;
                    REG_INTEG_LIM:
                    begin
                        integ_lim_reg <= cfg_data[LIM_W-1:0];
                        integ_reg     <= clamp_sym(SUM_W'(integ_reg), cfg_data[LIM_W-1:0]);
                    end
                    REG_OUT_LIM:    out_lim_reg    <= cfg_data[LIM_W-1:0];
                    default: ;
                endcase
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        if (opcode == OP_CLEAR)
                        begin
                            integ_reg <= '0;
                            last_reg  <= '0;
                            state_reg <= ST_FIN;
                        end
                        else if (time_step == '0)
                            state_reg <= ST_FIN;
                        else
                        begin
                            mul_start_reg <= 1'b1;
                            state_reg     <= ST_MUL_ET;
                        end
                    end
                end
                ST_MUL_ET:
                begin
                    if (mul_done)
                    begin
                        integ_reg     <= integ_new;
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        last_reg      <= err_reg;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_MUL_P;
                    end
                end
                ST_MUL_P:
                begin
                    if (mul_done)
                    begin
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_MUL_I;
                    end
                end
                ST_MUL_I:
                begin
                    if (mul_done)
                    begin
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_MUL_D;
                    end
                end
                ST_MUL_D:
                begin
                    if (mul_done)
                        state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    err_reg     <= error_sample;
                    dt_reg      <= time_step;
                    sum_reg     <= '0;
                    res_val_reg <= '0;
                    res_rej_reg <= (opcode == OP_UPDATE) && (time_step == '0);
                    mul_a_reg   <= error_sample[DATA_W-1] ? MUL_A_W'(-error_sample)
                                                          : MUL_A_W'(error_sample);
                    mul_b_reg   <= MUL_B_W'(time_step);
                end
            end
            ST_MUL_ET:
            begin
                if (mul_done)
                begin
                    div_n_reg    <= {diff_mag, {DT_FRAC{1'b0}}};
                    diff_neg_reg <= diff[32];
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    deriv_mag_reg <= MUL_B_W'(dq_sat);
                    deriv_neg_reg <= diff_neg_reg;
                    mul_a_reg     <= prop_gain_reg[DATA_W-1] ? MUL_A_W'(-prop_gain_reg)
                                                             : MUL_A_W'(prop_gain_reg);
                    mul_b_reg     <= MUL_B_W'(err_mag);
                    term_neg_reg  <= prop_gain_reg[DATA_W-1] ^ err_reg[DATA_W-1];
                end
            end
            ST_MUL_P:
            begin
                if (mul_done)
                begin
                    sum_reg      <= sum_next;
                    mul_a_reg    <= ig_mag;
                    mul_b_reg    <= MUL_B_W'(integ_mag);
                    term_neg_reg <= integ_gain_reg[DATA_W-1] ^ integ_reg[DATA_W-1];
                end
            end
            ST_MUL_I:
            begin
                if (mul_done)
                begin
                    sum_reg      <= sum_next;
                    mul_a_reg    <= dg_mag;
                    mul_b_reg    <= deriv_mag_reg;
                    term_neg_reg <= deriv_gain_reg[DATA_W-1] ^ deriv_neg_reg;
                end
            end
            ST_MUL_D:
            begin
                if (mul_done)
                    res_val_reg <= clamp_in;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_val_reg <= res_val_reg;
                    out_rej_reg <= res_rej_reg;
                end
            end
            default: ;
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign control_out   = out_val_reg;
    assign step_rejected = out_rej_reg;

endmodule
